// ===== design/aip_pkg.sv =====
// aip_pkg: shared types, codes and constants of the ascii integer parser
// no dependencies; used by aip_front, aip_back and the top level

package aip_pkg;

   localparam int MidDepth    = 4;
   localparam int ResultDepth = 2;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CsrNumberFormat = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrResultWidth  = 2'd1;

   localparam logic [1:0] FmtSignedDec   = 2'd0;
   localparam logic [1:0] FmtUnsignedDec = 2'd1;

   localparam logic [1:0] KindDigit = 2'd0;
   localparam logic [1:0] KindMinus = 2'd1;
   localparam logic [1:0] KindSkip  = 2'd2;
   localparam logic [1:0] KindBad   = 2'd3;

   localparam logic [7:0] AsciiZero   = 8'h30;
   localparam logic [7:0] AsciiNine   = 8'h39;
   localparam logic [7:0] AsciiUpperA = 8'h41;
   localparam logic [7:0] AsciiUpperF = 8'h46;
   localparam logic [7:0] AsciiLowerA = 8'h61;
   localparam logic [7:0] AsciiLowerF = 8'h66;
   localparam logic [7:0] AsciiMinus  = 8'h2d;
   localparam logic [7:0] AsciiPlus   = 8'h2b;

   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        bad_char;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] digit;
      logic       hex;
      logic       is_last;
      logic       wide;
   } entry_type;

endpackage

// ===== design/aip_fifo.sv =====
// aip_fifo: small register queue with push/full and pop/empty sides
// no dependencies; used by the top level for the middle and result queues

module aip_fifo #(
   parameter int DataWidth = 8,
   parameter int Depth     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DataWidth-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DataWidth-1:0] pop_data,
   output logic                 empty
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   logic [DataWidth-1:0]  store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/aip_front.sv =====
// aip_front: accepts characters and classifies them as digit, sign or bad
// depends on aip_pkg; feeds the middle aip_fifo

module aip_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  aip_pkg::req_type    req_data,
   input  logic [1:0]          number_format,
   input  logic                result_wide,
   input  logic                mid_full,
   output logic                mid_push,
   output aip_pkg::entry_type  mid_data
);

   logic       at_start_ff, at_start_in;
   logic       accept;
   logic       hex;
   logic       signed_dec;
   logic [7:0] ch;
   logic       is_dec, is_upper, is_lower;

   assign accept     = req_push && !mid_full;
   assign mid_push   = accept;
   assign ch         = req_data.character;
   assign signed_dec = (number_format == aip_pkg::FmtSignedDec);
   assign hex        = !signed_dec && (number_format != aip_pkg::FmtUnsignedDec);
   assign is_dec     = (ch >= aip_pkg::AsciiZero) && (ch <= aip_pkg::AsciiNine);
   assign is_upper   = hex && (ch >= aip_pkg::AsciiUpperA) && (ch <= aip_pkg::AsciiUpperF);
   assign is_lower   = hex && (ch >= aip_pkg::AsciiLowerA) && (ch <= aip_pkg::AsciiLowerF);

   always_comb begin
      mid_data.hex     = hex;
      mid_data.is_last = req_data.is_last;
      mid_data.wide    = result_wide;
      mid_data.digit   = ch[3:0];
      mid_data.kind    = aip_pkg::KindBad;
      if (is_dec) begin
         mid_data.kind = aip_pkg::KindDigit;
      end else if (is_upper) begin
         mid_data.kind  = aip_pkg::KindDigit;
         mid_data.digit = 4'(ch - aip_pkg::AsciiUpperA + 8'd10);
      end else if (is_lower) begin
         mid_data.kind  = aip_pkg::KindDigit;
         mid_data.digit = 4'(ch - aip_pkg::AsciiLowerA + 8'd10);
      end else if (signed_dec && at_start_ff && ch == aip_pkg::AsciiMinus) begin
         mid_data.kind = aip_pkg::KindMinus;
      end else if (signed_dec && at_start_ff && ch == aip_pkg::AsciiPlus) begin
         mid_data.kind = aip_pkg::KindSkip;
      end
   end

   always_comb begin
      at_start_in = at_start_ff;
      if (accept) begin
         at_start_in = req_data.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

endmodule

// ===== design/aip_back.sv =====
// aip_back: accumulates classified characters and finishes one value per field
// depends on aip_pkg; drains the middle aip_fifo, fills the result aip_fifo

module aip_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                mid_empty,
   input  aip_pkg::entry_type  mid_data,
   output logic                mid_pop,
   input  logic                res_full,
   output logic                res_push,
   output aip_pkg::rsp_type    res_data
);

   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        inv_ff, inv_in;
   logic        fin_valid_ff, fin_valid_in;
   logic [63:0] fin_acc_ff, fin_acc_in;
   logic        fin_neg_ff, fin_neg_in;
   logic        fin_inv_ff, fin_inv_in;
   logic        fin_wide_ff, fin_wide_in;
   logic [63:0] acc_step;
   logic [63:0] signed_val;
   logic        fin_free;

   assign fin_free = !fin_valid_ff || !res_full;
   assign mid_pop  = !mid_empty && fin_free;
   assign res_push = fin_valid_ff;

   always_comb begin
      if (mid_data.hex) begin
         acc_step = {acc_ff[59:0], mid_data.digit};
      end else begin
         acc_step = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} + 64'(mid_data.digit);
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      inv_in       = inv_ff;
      fin_valid_in = fin_valid_ff && res_full;
      fin_acc_in   = fin_acc_ff;
      fin_neg_in   = fin_neg_ff;
      fin_inv_in   = fin_inv_ff;
      fin_wide_in  = fin_wide_ff;
      if (mid_pop) begin
         case (mid_data.kind)
            aip_pkg::KindDigit: acc_in = acc_step;
            aip_pkg::KindMinus: neg_in = 1'b1;
            aip_pkg::KindSkip:  acc_in = acc_ff;
            default:            inv_in = 1'b1;
         endcase
         if (mid_data.is_last) begin
            fin_valid_in = 1'b1;
            fin_acc_in   = acc_in;
            fin_neg_in   = neg_in;
            fin_inv_in   = inv_in;
            fin_wide_in  = mid_data.wide;
            acc_in       = '0;
            neg_in       = 1'b0;
            inv_in       = 1'b0;
         end
      end
   end

   always_comb begin
      signed_val = fin_neg_ff ? (64'd0 - fin_acc_ff) : fin_acc_ff;
      if (!fin_wide_ff) begin
         signed_val = {32'd0, signed_val[31:0]};
      end
      res_data.value    = fin_inv_ff ? 64'd0 : signed_val;
      res_data.bad_char = fin_inv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         inv_ff       <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         inv_ff       <= inv_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_acc_ff  <= fin_acc_in;
      fin_neg_ff  <= fin_neg_in;
      fin_inv_ff  <= fin_inv_in;
      fin_wide_ff <= fin_wide_in;
   end

endmodule

// ===== design/ascii_integer_parser.sv =====
// ascii_integer_parser: top level, config registers, front, queues and back
// depends on aip_pkg, aip_fifo, aip_front and aip_back
//
//   channel  ports                                     direction
//   req      req_push, req_full, req_data              character in, one a transaction
//   rsp      rsp_empty, rsp_pop, rsp_data              one value per field out
//   csr      csr_valid, csr_ready, csr_index, csr_data register write, always ready
//
// one character and one back accumulator shift-add a cycle while nothing stalls
// a result passes the middle queue, finish register and result queue to rsp
// req_full rises only when the middle queue fills behind a stalled result queue
// synchronous reset empties both queues and starts a new field

module ascii_integer_parser #(
   parameter int MidDepth    = aip_pkg::MidDepth,
   parameter int ResultDepth = aip_pkg::ResultDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  aip_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output aip_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aip_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aip_pkg::CsrDataWidth-1:0]  csr_data
);

   logic [1:0]         format_ff, format_in;
   logic               wide_ff, wide_in;
   logic               mid_push, mid_full, mid_pop, mid_empty;
   aip_pkg::entry_type mid_wr, mid_rd;
   logic               res_push, res_full;
   aip_pkg::rsp_type   res_data;

   assign csr_ready = 1'b1;

   always_comb begin
      format_in = format_ff;
      wide_in   = wide_ff;
      if (csr_valid && csr_index == aip_pkg::CsrNumberFormat) begin
         format_in = csr_data[1:0];
      end
      if (csr_valid && csr_index == aip_pkg::CsrResultWidth) begin
         wide_in = csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= aip_pkg::FmtSignedDec;
         wide_ff   <= 1'b0;
      end else begin
         format_ff <= format_in;
         wide_ff   <= wide_in;
      end
   end

   aip_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .number_format (format_ff),
      .result_wide   (wide_ff),
      .mid_full      (mid_full),
      .mid_push      (mid_push),
      .mid_data      (mid_wr)
   );

   assign req_full = mid_full;

   aip_fifo #(
      .DataWidth ($bits(aip_pkg::entry_type)),
      .Depth     (MidDepth)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rd),
      .empty     (mid_empty)
   );

   aip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd),
      .mid_pop   (mid_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   aip_fifo #(
      .DataWidth ($bits(aip_pkg::rsp_type)),
      .Depth     (ResultDepth)
   ) u_res_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   a_res_held: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_full) |=> (res_push && $stable(res_data)))
      else $error("finished result changed while the result queue was full");

   a_mid_no_underflow: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("middle queue popped while empty");

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.bad_char) |-> (rsp_data.value == 64'd0))
      else $error("bad character result is not zero");

endmodule
